// ----- hw/rtl/efws_pkg.sv -----
// Shared types and constants for the earliest-free worker scheduler.
package efws_pkg;

  localparam int WORKERS = 16;
  localparam int IDX_W   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CNT_W   = $clog2(WORKERS + 1);
  localparam int TIME_W  = 48;
  localparam int DUR_W   = 32;
  localparam int CFG_W   = 5;
  localparam int WIDX_W  = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Search packet handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [CNT_W-1:0]  idx;
    logic [TIME_W-1:0] ftime;
  } search_t;

  // Free-time write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  idx;
    logic [TIME_W-1:0] value;
  } update_t;

  // Clamp the register value to 1..WORKERS.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > WORKERS) begin
      r = CNT_W'(WORKERS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/efws_cell.sv -----
// One worker cell: holds a free time and refines the passing search packet.
module efws_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [efws_pkg::CNT_W-1:0] idx,
  input  logic [efws_pkg::CNT_W-1:0] active_cnt,
  input  efws_pkg::search_t         search_in,
  output efws_pkg::search_t         search_out,
  input  efws_pkg::update_t         upd
);

  logic [efws_pkg::TIME_W-1:0] free_time;
  logic                        active;
  logic                        take;
  efws_pkg::search_t           search_next;

  assign active = idx < active_cnt;
  // strict compare keeps the lower worker on ties
  assign take = search_in.valid && active &&
                (!search_in.found || (free_time < search_in.ftime));

  always_comb begin
    search_next = search_in;
    if (take) begin
      search_next.found = 1'b1;
      search_next.idx   = idx;
      search_next.ftime = free_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_time        <= '0;
      search_out.valid <= 1'b0;
    end else begin
      search_out.valid <= search_next.valid;
      if (upd.en && (upd.idx == idx)) begin
        free_time <= upd.value;
      end
    end
    search_out.found <= search_next.found;
    search_out.idx   <= search_next.idx;
    search_out.ftime <= search_next.ftime;
  end

endmodule

// ----- hw/rtl/earliest_free_worker_scheduler_top.sv -----
// Top level of the earliest-free worker scheduler: cell chain, control and output register.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata[31:0] job_duration
//   m_*       out        m_tvalid / m_tready  m_tdata[3:0] worker_index, [51:4] start_time
//   cfg_*     in         cfg_wr_en            cfg_wr_data[4:0] active_workers
//
// A job passes these steps from transfer in to the next possible transfer in: the
// inject register, the search packet walks the WORKERS cells one per cycle, then the
// capture of the winner and the load of the output register, back in IDLE after that.
// The input takes no new job before the block is back in IDLE.
// Reset clears all free times and sets the active count to WORKERS.
// While a result waits, the next finished job stays in HOLD and the input is blocked;
// its free-time write is issued as it moves into the output register.
module earliest_free_worker_scheduler_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [efws_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] job_duration
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [efws_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [3:0] worker_index, [51:4] start_time
  input  logic                                cfg_wr_en,
  input  logic [efws_pkg::CFG_W-1:0]          cfg_wr_data // [4:0] active_workers
);

  typedef enum logic [1:0] {IDLE, SCAN, HOLD} state_t;

  state_t                        state;
  logic                          inject;
  logic [efws_pkg::DUR_W-1:0]    dur;
  logic [efws_pkg::CNT_W-1:0]    active_cnt;
  logic [efws_pkg::CNT_W-1:0]    best_idx;
  logic [efws_pkg::TIME_W-1:0]   best_time;
  logic [efws_pkg::TIME_W:0]     sum;
  logic [efws_pkg::TIME_W-1:0]   sum_sat;
  logic                          out_free;
  efws_pkg::update_t             upd;
  efws_pkg::search_t             links [efws_pkg::WORKERS+1];
  logic [efws_pkg::WORKERS-1:0]  link_valid;
  efws_pkg::search_t             last;

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign last     = links[efws_pkg::WORKERS];

  assign sum     = {1'b0, best_time} + {{(efws_pkg::TIME_W+1-efws_pkg::DUR_W){1'b0}}, dur};
  assign sum_sat = sum[efws_pkg::TIME_W] ? {efws_pkg::TIME_W{1'b1}}
                                         : sum[efws_pkg::TIME_W-1:0];

  always_comb begin
    links[0]       = '0;
    links[0].valid = inject;
  end

  for (genvar i = 0; i < efws_pkg::WORKERS; i++) begin : g_cell
    efws_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (efws_pkg::CNT_W'(i)),
      .active_cnt (active_cnt),
      .search_in  (links[i]),
      .search_out (links[i+1]),
      .upd        (upd)
    );
    assign link_valid[i] = links[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      inject     <= 1'b0;
      m_tvalid   <= 1'b0;
      upd.en     <= 1'b0;
      active_cnt <= efws_pkg::CNT_W'(efws_pkg::WORKERS);
    end else begin
      inject <= 1'b0;
      upd.en <= 1'b0;
      if (cfg_wr_en) begin
        active_cnt <= efws_pkg::clamp_count(cfg_wr_data);
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            inject <= 1'b1;
            state  <= SCAN;
          end
        end
        SCAN: begin
          if (last.valid) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            upd.en   <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    if (s_tvalid && s_tready) begin
      dur <= s_tdata[efws_pkg::DUR_W-1:0];
    end
    if (state == SCAN && last.valid) begin
      best_idx  <= last.idx;
      best_time <= last.ftime;
    end
    if (state == HOLD && out_free) begin
      m_tdata   <= {(efws_pkg::OUT_TDATA_W-efws_pkg::WIDX_W-efws_pkg::TIME_W)'(0),
                    best_time, efws_pkg::WIDX_W'(best_idx)};
      upd.idx   <= best_idx;
      upd.value <= sum_sat;
    end
  end

  // only one search packet is ever in the chain
  assert property (@(posedge clk) disable iff (rst) $onehot0(link_valid))
    else $error("more than one search packet in the cell chain");

  assert property (@(posedge clk) disable iff (rst) last.valid |-> state == SCAN)
    else $error("search packet left the chain outside a scan");

  assert property (@(posedge clk) disable iff (rst) upd.en |-> m_tvalid && state == IDLE)
    else $error("free-time write without a matching result");

  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> inject)
    else $error("accepted job did not start a scan");

  assert property (@(posedge clk) disable iff (rst) last.valid |-> last.found)
    else $error("scan finished without selecting a worker");

endmodule
